>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the command-line tokenizer; expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define CLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CLT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and helpers of the command-line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int CLT_BUF_LEN   = 256;
  localparam int CLT_MAX_WORDS = 16;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SEPARATOR = 8'h00;

  localparam logic [1:0] ACT_RX     = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_RDWORD = 2'd2;
  localparam logic [1:0] ACT_RDBYTE = 2'd3;

  localparam logic CFG_DELIM_LEN   = 1'b0;
  localparam logic CFG_DELIM_BYTES = 1'b1;

  localparam logic [1:0]  DELIM_LEN_RST   = 2'd2;
  localparam logic [15:0] DELIM_BYTES_RST = 16'h0D0A;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] index;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic       line_done;
    logic [4:0] word_count;
    logic [7:0] line_length;
    logic [7:0] read_byte;
    logic [7:0] word_start;
    logic [7:0] word_length;
  } out_item_t;

  // a - b, floored at zero, low byte kept
  function automatic logic [7:0] diff8(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (a >= b) ? d[7:0] : 8'd0;
  endfunction

endpackage

>>> sv/clt_stream_if.sv
// ----------------------------------------------------------------------------
// clt_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface clt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Line editor with word tokenizer: stores command-line bytes, tracks words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one action per item: receive a byte, clear the line, read a
//   word entry or read a buffer byte. out_ch returns exactly one result per
//   item: status, line flag, word count, line length and the read-back data.
//   cfg_we/cfg_index/cfg_wdata set the end-of-line delimiter (length, bytes);
//   write them only while no item is in flight.
//   An accepted item passes the input register (with the memory read),
//   then the result register, which drives out_ch.
//   Throughput: one item per cycle unless out_ch stalls; the line buffer
//   has even/odd banks: a delimiter byte and its separator share a cycle.
//   Reset clears counters, word valid flags, line flag and delimiter (CR LF);
//   buffer bytes are not cleared and must not be read before written.
//   Stall: when out_ch.ready is low the result holds, the next item waits in
//   the input register, and in_ch.ready drops only when both are occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module command_line_tokenizer_unit
  import clt_pkg::*;
#(
  parameter int BUF_LEN   = CLT_BUF_LEN,
  parameter int MAX_WORDS = CLT_MAX_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  clt_stream_if.sink   in_ch,
  clt_stream_if.source out_ch
);

  localparam int AW     = $clog2(BUF_LEN);
  localparam int WW     = $clog2(MAX_WORDS);
  localparam int WDEPTH = 2**WW;

  // configuration
  logic [1:0]  delim_len_r;
  logic [15:0] delim_bytes_r;

  // input register
  logic        v_r;
  logic [1:0]  act_r;
  logic [7:0]  rx_r;
  logic [7:0]  idx_r;

  // line state
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [WW-1:0]     wn_r, wn_nxt;
  logic [7:0]        piw_r, piw_nxt;
  logic              lc_r, lc_nxt;
  logic [WDEPTH-1:0] wt_vld_r, wt_vld_nxt;

  // result register
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic adv, fire, acc, err;

  // buffer write requests (second one only for the separator of a delimiter)
  logic          we1, we2;
  logic [AW-1:0] wa1, wa2;
  logic [7:0]    wd1;

  logic [1:0]    bank_we;
  logic [AW-2:0] bank_wa [2];
  logic [7:0]    bank_wd [2];
  logic [7:0]    bufa_rd [2];
  logic [7:0]    bufb_rd [2];
  logic [AW-1:0] idx_a, rb_a;

  logic          wt_we;
  logic [15:0]   wt_wd, wta_rd, wtb_rd;

  logic [AW-1:0] wp_m1, wp_p1;
  logic [WW-1:0] wn_m1;
  logic [7:0]    last_byte, prev_len, piw_inc;
  logic          dl2, at_end;
  logic [WW:0]   wn_inc;
  logic          idx_in_buf, idx_in_wt;

  assign adv  = !out_valid_r || out_ch.ready;
  assign fire = v_r && adv;
  assign in_ch.ready = !v_r || adv;
  assign acc  = in_ch.valid && in_ch.ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= DELIM_LEN_RST;
      delim_bytes_r <= DELIM_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIM_LEN:   delim_len_r   <= cfg_wdata[1:0];
        CFG_DELIM_BYTES: delim_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      act_r <= in_ch.data.action;
      rx_r  <= in_ch.data.rx_byte;
      idx_r <= in_ch.data.index;
    end
  end

  assign wp_m1     = wp_r - AW'(1);
  assign wp_p1     = wp_r + AW'(1);
  assign wn_m1     = wn_r - WW'(1);
  assign last_byte = wp_m1[0] ? bufb_rd[1] : bufb_rd[0];
  assign prev_len  = wt_vld_r[wn_m1] ? wtb_rd[7:0] : 8'd0;
  assign piw_inc   = (piw_r == 8'hFF) ? piw_r : piw_r + 8'd1;
  assign dl2       = delim_len_r >= 2'd2;
  assign at_end    = dl2 ? (wp_r != '0 && last_byte == delim_bytes_r[15:8] &&
                            rx_r == delim_bytes_r[7:0])
                         : (rx_r == delim_bytes_r[7:0]);

  always_comb begin
    wp_nxt     = wp_r;
    wn_nxt     = wn_r;
    piw_nxt    = piw_r;
    lc_nxt     = lc_r;
    wt_vld_nxt = wt_vld_r;
    err        = 1'b0;
    we1        = 1'b0;
    wa1        = wp_r;
    wd1        = rx_r;
    we2        = 1'b0;
    wa2        = wp_m1;
    wt_we      = 1'b0;
    wt_wd      = '0;
    if (fire) begin
      case (act_r)
        ACT_RX: begin
          if (rx_r == CH_BACKSPACE) begin
            if (wp_r != '0) begin
              // erasing a separator reopens the previous word
              if (last_byte == CH_SEPARATOR && wn_r != '0) begin
                wn_nxt            = wn_m1;
                piw_nxt           = prev_len;
                wt_vld_nxt[wn_m1] = 1'b0;
              end else if (piw_r != 8'd0) begin
                piw_nxt = piw_r - 8'd1;
              end
              wp_nxt = wp_m1;
            end
          end else if (wp_r >= AW'(BUF_LEN - 1)) begin
            err = 1'b1;
          end else if (rx_r == CH_SPACE) begin
            if (wn_r >= WW'(MAX_WORDS - 1)) begin
              err = 1'b1;
            end else begin
              we1              = 1'b1;
              wd1              = CH_SEPARATOR;
              wp_nxt           = wp_p1;
              wt_we            = 1'b1;
              wt_wd            = {diff8(16'(wp_p1), 16'(piw_r) + 16'd1), piw_r};
              wn_nxt           = wn_r + WW'(1);
              piw_nxt          = 8'd0;
              wt_vld_nxt[wn_r] = 1'b1;
            end
          end else begin
            we1     = 1'b1;
            wp_nxt  = wp_p1;
            piw_nxt = piw_inc;
            if (at_end) begin
              // first delimiter byte becomes the separator
              if (dl2) begin
                we2 = 1'b1;
              end else begin
                wd1 = CH_SEPARATOR;
              end
              wt_we            = 1'b1;
              wt_wd            = {diff8(16'(wp_p1), 16'(piw_inc)),
                                  diff8(16'(piw_inc), dl2 ? 16'd2 : 16'd1)};
              wt_vld_nxt[wn_r] = 1'b1;
              lc_nxt           = 1'b1;
            end
          end
          if (err) begin
            wp_nxt     = '0;
            wn_nxt     = '0;
            piw_nxt    = 8'd0;
            lc_nxt     = 1'b0;
            wt_vld_nxt = '0;
          end
        end
        ACT_CLEAR: begin
          wp_nxt     = '0;
          wn_nxt     = '0;
          piw_nxt    = 8'd0;
          lc_nxt     = 1'b0;
          wt_vld_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      wn_r     <= '0;
      piw_r    <= 8'd0;
      lc_r     <= 1'b0;
      wt_vld_r <= '0;
    end else begin
      wp_r     <= wp_nxt;
      wn_r     <= wn_nxt;
      piw_r    <= piw_nxt;
      lc_r     <= lc_nxt;
      wt_vld_r <= wt_vld_nxt;
    end
  end

  // route the two buffer writes to their banks; they never share one
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bank_we[b] = (we1 && wa1[0] == 1'(b)) || (we2 && wa2[0] == 1'(b));
      if (we1 && wa1[0] == 1'(b)) begin
        bank_wa[b] = wa1[AW-1:1];
        bank_wd[b] = wd1;
      end else begin
        bank_wa[b] = wa2[AW-1:1];
        bank_wd[b] = CH_SEPARATOR;
      end
    end
  end

  assign idx_a = AW'(in_ch.data.index);
  // keep port B on the byte before the next write position
  assign rb_a  = wp_nxt - AW'(1);

  for (genvar g = 0; g < 2; g++) begin : g_bank
    clt_dpram #(.DW(8), .AW(AW - 1)) u_bank (
      .clk     (clk),
      .we      (bank_we[g]),
      .waddr   (bank_wa[g]),
      .wdata   (bank_wd[g]),
      .ra_en   (acc),
      .ra_addr (idx_a[AW-1:1]),
      .ra_data (bufa_rd[g]),
      .rb_addr (rb_a[AW-1:1]),
      .rb_data (bufb_rd[g])
    );
  end

  clt_dpram #(.DW(16), .AW(WW)) u_wtbl (
    .clk     (clk),
    .we      (wt_we),
    .waddr   (wn_r),
    .wdata   (wt_wd),
    .ra_en   (acc),
    .ra_addr (WW'(in_ch.data.index)),
    .ra_data (wta_rd),
    .rb_addr (wn_nxt - WW'(1)),
    .rb_data (wtb_rd)
  );

  assign idx_in_buf = 32'(idx_r) < BUF_LEN;
  assign idx_in_wt  = 32'(idx_r) < MAX_WORDS;
  assign wn_inc     = {1'b0, wn_nxt} + (WW + 1)'(1);

  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = err;
    out_nxt.line_done   = lc_nxt;
    out_nxt.word_count  = (wp_nxt != '0) ? 5'(wn_inc) : 5'd0;
    out_nxt.line_length = 8'(wp_nxt);
    if (act_r == ACT_RDBYTE && idx_in_buf) begin
      out_nxt.read_byte = idx_r[0] ? bufa_rd[1] : bufa_rd[0];
    end
    if (act_r == ACT_RDWORD && idx_in_wt && wt_vld_r[WW'(idx_r)]) begin
      out_nxt.word_start  = wta_rd[15:8];
      out_nxt.word_length = wta_rd[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  `CLT_ASSERT(a_wp_bound, wp_r <= AW'(BUF_LEN - 1), "write position past buffer end")
  `CLT_ASSERT_NEXT(a_clear, fire && act_r == ACT_CLEAR,
                   wp_r == '0 && wn_r == '0 && !lc_r, "clear left line state")
  `CLT_ASSERT_IMPL(a_err_empty, out_valid_r && out_r.status,
                   out_r.line_length == 8'd0 && out_r.word_count == 5'd0,
                   "error result with nonempty line")
  `CLT_ASSERT_IMPL(a_stall, !in_ch.ready, v_r && out_valid_r && !out_ch.ready,
                   "input stalled without backpressure")

endmodule

>>> sv/clt_dpram.sv
// ----------------------------------------------------------------------------
// clt_dpram
// One write port, two registered read ports with write-through forwarding.
// ----------------------------------------------------------------------------
module clt_dpram #(
  parameter int DW = 8,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          ra_en,
  input  logic [AW-1:0] ra_addr,
  output logic [DW-1:0] ra_data,
  input  logic [AW-1:0] rb_addr,
  output logic [DW-1:0] rb_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // port A loads on request only and holds otherwise
  always_ff @(posedge clk) begin
    if (ra_en) begin
      ra_data <= (we && waddr == ra_addr) ? wdata : mem[ra_addr];
    end
  end

  always_ff @(posedge clk) begin
    rb_data <= (we && waddr == rb_addr) ? wdata : mem[rb_addr];
  end

endmodule
